@@ src/assert_macros.svh @@
// Assertion helper macros shared by the splitter RTL.
// Clocked, reset-gated property checks; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MEWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MEWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MEWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/mews_pkg.sv @@
// Types and constants for the encoded-word splitter.
// No dependencies; used by mews_core, mews_res_fifo and the top level.
package mews_pkg;

    typedef enum logic [1:0] {
        PH_OPEN  = 2'd0,
        PH_ENC   = 2'd1,
        PH_CLOSE = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_B     = 2'd1;
    localparam logic [1:0] KIND_Q     = 2'd2;

    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_Q    = 8'h51;

    localparam logic [4:0] CS_CAP = 5'd31;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int TDATA_W = 40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  doff;
        logic [10:0] dlen;
        logic [9:0]  coff;
        logic [4:0]  clen;
        logic        fin;
    } elem_t;

    typedef struct packed {
        logic [1:0] n;
        elem_t      e0;
        elem_t      e1;
    } push_t;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

@@ src/mews_core.sv @@
// Per-byte scanner: marker history, phase and span registers, result forming.
// Depends on mews_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mews_core #(
    parameter int LINE_MAX_LEN = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    output mews_pkg::push_t      push
);
    localparam int POS_W = $clog2(LINE_MAX_LEN + 1);
    localparam int PW    = (POS_W > 11) ? POS_W : 11;
    localparam logic [PW-1:0] LMAX = PW'(LINE_MAX_LEN);

    logic [PW-1:0]     pos_reg, pos_next;
    mews_pkg::phase_t  phase_reg, phase_next;
    logic [PW-1:0]     plain_start_reg, plain_start_next;
    logic [PW-1:0]     word_start_reg, word_start_next;
    logic [PW-1:0]     cs_begin_reg, cs_begin_next;
    logic [4:0]        cs_count_reg, cs_count_next;
    logic              star_reg, star_next;
    logic              enc_reg, enc_next;
    logic [PW-1:0]     pay_start_reg, pay_start_next;
    logic [7:0]        h0_reg, h0_next, h1_reg, h1_next;
    logic [1:0]        hv_reg, hv_next;
    logic [7:0]        count_reg, count_next;
    logic              stopped_reg, stopped_next;
    logic [7:0]        max_reg;

    logic              active;
    logic [PW-1:0]     pos_inc;
    logic [7:0]        u;
    logic [PW-1:0]     cs_diff, cs_raw, pay_len, word_len, rem_len;
    logic              open_hit, enc_hit, close_hit, star_hit, fin;
    logic [8:0]        cnt9;

    assign active   = in_take && !stopped_reg && (pos_reg < LMAX);
    assign pos_inc  = pos_reg + PW'(1);
    assign u        = mews_pkg::up_case(h1_reg);
    assign cs_diff  = pos_reg - cs_begin_reg;
    assign cs_raw   = pos_reg - PW'(2) - cs_begin_reg;
    assign pay_len  = pos_reg - PW'(1) - pay_start_reg;
    assign word_len = word_start_reg - plain_start_reg;
    assign cnt9     = {1'b0, count_reg} + 9'd2;

    assign open_hit  = (phase_reg == mews_pkg::PH_OPEN) && (hv_reg != 2'd0)
                       && (h1_reg == mews_pkg::CH_EQ) && (in_byte == mews_pkg::CH_QM);
    assign star_hit  = (in_byte == mews_pkg::CH_STAR) && !star_reg && (cs_diff < PW'(31));
    assign enc_hit   = (phase_reg == mews_pkg::PH_ENC) && (hv_reg == 2'd2)
                       && (h0_reg == mews_pkg::CH_QM) && (in_byte == mews_pkg::CH_QM)
                       && ((u == mews_pkg::CH_B) || (u == mews_pkg::CH_Q));
    assign close_hit = (phase_reg == mews_pkg::PH_CLOSE) && (hv_reg != 2'd0)
                       && (h1_reg == mews_pkg::CH_QM) && (in_byte == mews_pkg::CH_EQ);
    assign fin       = (cnt9 >= {1'b0, max_reg}) || in_last || (pos_inc >= LMAX);

    // remainder span ends at the advanced position
    assign rem_len = (active ? pos_inc : pos_reg) - plain_start_reg;

    // next-state logic
    always_comb
    begin
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        plain_start_next = plain_start_reg;
        word_start_next  = word_start_reg;
        cs_begin_next    = cs_begin_reg;
        cs_count_next    = cs_count_reg;
        star_next        = star_reg;
        enc_next         = enc_reg;
        pay_start_next   = pay_start_reg;
        h0_next          = h0_reg;
        h1_next          = h1_reg;
        hv_next          = hv_reg;
        count_next       = count_reg;
        stopped_next     = stopped_reg;
        if (active)
        begin
            case (phase_reg)
                mews_pkg::PH_OPEN:
                begin
                    if (open_hit)
                    begin
                        word_start_next = pos_reg - PW'(1);
                        cs_begin_next   = pos_inc;
                        cs_count_next   = 5'd0;
                        star_next       = 1'b0;
                        phase_next      = mews_pkg::PH_ENC;
                    end
                end
                mews_pkg::PH_ENC:
                begin
                    if (star_hit)
                    begin
                        star_next     = 1'b1;
                        cs_count_next = cs_diff[4:0];
                    end
                    if (enc_hit)
                    begin
                        if (!star_next)
                        begin
                            cs_count_next = (cs_raw > PW'(31)) ? mews_pkg::CS_CAP
                                                               : cs_raw[4:0];
                        end
                        enc_next       = (u == mews_pkg::CH_Q);
                        pay_start_next = pos_inc;
                        phase_next     = mews_pkg::PH_CLOSE;
                    end
                end
                mews_pkg::PH_CLOSE:
                begin
                    if (close_hit)
                    begin
                        count_next       = cnt9[8] ? 8'hFF : cnt9[7:0];
                        plain_start_next = pos_inc;
                        phase_next       = mews_pkg::PH_OPEN;
                        star_next        = 1'b0;
                        cs_count_next    = 5'd0;
                        stopped_next     = fin;
                    end
                end
                default:
                begin
                    phase_next = mews_pkg::PH_OPEN;
                end
            endcase
            if (open_hit || enc_hit || close_hit)
            begin
                h0_next = 8'd0;
                h1_next = 8'd0;
                hv_next = 2'd0;
            end
            else
            begin
                h0_next = h1_reg;
                h1_next = in_byte;
                hv_next = (hv_reg == 2'd2) ? 2'd2 : hv_reg + 2'd1;
            end
            pos_next = pos_inc;
        end
        if (in_take && in_last)
        begin
            pos_next         = '0;
            phase_next       = mews_pkg::PH_OPEN;
            plain_start_next = '0;
            word_start_next  = '0;
            cs_begin_next    = '0;
            cs_count_next    = 5'd0;
            star_next        = 1'b0;
            enc_next         = 1'b0;
            pay_start_next   = '0;
            h0_next          = 8'd0;
            h1_next          = 8'd0;
            hv_next          = 2'd0;
            count_next       = 8'd0;
            stopped_next     = 1'b0;
        end
    end

    // result forming
    always_comb
    begin
        push = '0;
        if (active && close_hit)
        begin
            push.n       = 2'd2;
            push.e0.kind = mews_pkg::KIND_PLAIN;
            push.e0.doff = plain_start_reg[9:0];
            push.e0.dlen = word_len[10:0];
            push.e1.kind = enc_reg ? mews_pkg::KIND_Q : mews_pkg::KIND_B;
            push.e1.doff = pay_start_reg[9:0];
            push.e1.dlen = pay_len[10:0];
            push.e1.coff = cs_begin_reg[9:0];
            push.e1.clen = cs_count_reg;
            push.e1.fin  = fin;
        end
        else if (in_take && in_last && !stopped_reg)
        begin
            push.n       = 2'd1;
            push.e0.kind = mews_pkg::KIND_PLAIN;
            push.e0.doff = plain_start_reg[9:0];
            push.e0.dlen = rem_len[10:0];
            push.e0.fin  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            phase_reg       <= mews_pkg::PH_OPEN;
            plain_start_reg <= '0;
            word_start_reg  <= '0;
            cs_begin_reg    <= '0;
            cs_count_reg    <= 5'd0;
            star_reg        <= 1'b0;
            enc_reg         <= 1'b0;
            pay_start_reg   <= '0;
            h0_reg          <= 8'd0;
            h1_reg          <= 8'd0;
            hv_reg          <= 2'd0;
            count_reg       <= 8'd0;
            stopped_reg     <= 1'b0;
            max_reg         <= 8'd64;
        end
        else
        begin
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            plain_start_reg <= plain_start_next;
            word_start_reg  <= word_start_next;
            cs_begin_reg    <= cs_begin_next;
            cs_count_reg    <= cs_count_next;
            star_reg        <= star_next;
            enc_reg         <= enc_next;
            pay_start_reg   <= pay_start_next;
            h0_reg          <= h0_next;
            h1_reg          <= h1_next;
            hv_reg          <= hv_next;
            count_reg       <= count_next;
            stopped_reg     <= stopped_next;
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
        end
    end

    `MEWS_ASSERT_IMP(a_stop_phase, clk, rst_n, stopped_reg, phase_reg == mews_pkg::PH_OPEN, "stopped outside opener search")
    `MEWS_ASSERT(a_pos_range, clk, rst_n, pos_reg <= LMAX, "position beyond line limit")

endmodule

@@ src/mews_res_fifo.sv @@
// Four-entry result queue; takes up to two elements a cycle, gives one.
// Depends on mews_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mews_res_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mews_pkg::push_t       push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mews_pkg::elem_t       out_elem
);
    localparam int QD = mews_pkg::QDEPTH;
    localparam int AW = mews_pkg::QPTR_W;
    localparam int CW = mews_pkg::QCNT_W;

    mews_pkg::elem_t mem_reg [QD];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;
    logic [AW-1:0]   wr_ptr_inc;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_elem   = mem_reg[rd_ptr_reg];
    // room for a full pair; drops when a stalled output leaves fewer than two entries free
    assign room       = (count_reg <= CW'(QD - 2));
    assign wr_ptr_inc = wr_ptr_reg + AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.n);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.e0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.e1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MEWS_ASSERT(a_cnt_max, clk, rst_n, count_reg <= CW'(QD), "result queue count overflow")
    `MEWS_ASSERT_IMP(a_no_ovf, clk, rst_n, push.n != 2'd0, ({1'b0, count_reg} + (CW+1)'(push.n)) <= (CW+1)'(QD), "push into full result queue")

endmodule

@@ src/mime_encoded_word_splitter_top.sv @@
// Top level of the encoded-word splitter: stream ports, scanner, result queue.
// Depends on mews_pkg, mews_core and mews_res_fifo.
//
// Usage:
//   s_axis carries the raw bytes of one header line, one byte per word;
//   s_axis_tlast marks the final byte of the line.
//   m_axis carries the elements found: tuser is the kind (plain, B or Q word),
//   tdata the text/payload and charset spans, tlast the last element of a line.
//   cfg_we/cfg_wdata set the element limit (reset value 64); write it only
//   while no line is in progress.
// Timing:
//   Each byte is decided in the cycle it is taken; its elements are
//   registered into the result queue. One byte per cycle is accepted as
//   long as the four-entry result queue has room for two elements; a byte
//   that closes a word yields two elements, so a run of such bytes drains
//   at one element per cycle on the output side while m_axis_tready is high.
// Reset clears the scanner to the start of a line and empties the queue.
// When m_axis_tready is low the queue fills and s_axis_tready drops once
// fewer than two entries are free; nothing is lost or reordered.
module mime_encoded_word_splitter_top #(
    parameter int LINE_MAX_LEN = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] header_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [9:0] data_offset, [20:10] data_length, [30:21] charset_offset,
    // [35:31] charset_length, [39:36] zero
    output logic [mews_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,   // [1:0] element_kind
    output logic                             m_axis_tlast,
    input  logic                             cfg_we,
    input  logic [7:0]                       cfg_wdata
);
    logic             take;
    mews_pkg::push_t  push;
    mews_pkg::elem_t  elem;

    assign take = s_axis_tvalid && s_axis_tready;

    mews_core #(
        .LINE_MAX_LEN (LINE_MAX_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (take),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    mews_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_elem  (elem)
    );

    assign m_axis_tdata = {4'd0, elem.clen, elem.coff, elem.dlen, elem.doff};
    assign m_axis_tuser = elem.kind;
    assign m_axis_tlast = elem.fin;

endmodule

@@ dv/mews_element_checker.sv @@
`timescale 1ns / 1ps
// Element checker for the encoded-word splitter: predicts the elements that each
// accepted header byte yields and compares them with the words leaving m_axis.
// Depends on mews_pkg; instantiated by tb_top beside the block.
module mews_element_checker #(
    parameter int LINE_MAX_LEN = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [mews_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic [1:0]                   m_axis_tuser,
    input  logic                         m_axis_tlast,
    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_wdata,
    output int                           fail_count,
    output int                           pending
);
    logic [7:0]        limit;
    int unsigned       pos;
    int unsigned       plain_start;
    int unsigned       word_start;
    int unsigned       cs_begin;
    int unsigned       cs_count;
    int unsigned       pay_start;
    int unsigned       elem_count;
    mews_pkg::phase_t  ph;
    bit                star_seen;
    bit                enc_q;
    bit                halted;
    logic [7:0]        hist_old;
    logic [7:0]        hist_new;
    int unsigned       hist_n;

    mews_pkg::elem_t   pending_elements[$];
    mews_pkg::elem_t   want;
    bit                bad;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? (c ^ 8'h20) : c;
    endfunction

    task automatic forget_history();
        hist_old = 8'd0;
        hist_new = 8'd0;
        hist_n   = 0;
    endtask

    task automatic shift_history(input logic [7:0] b);
        hist_old = hist_new;
        hist_new = b;
        if (hist_n < 2)
        begin
            hist_n++;
        end
    endtask

    task automatic start_line();
        pos         = 0;
        ph          = mews_pkg::PH_OPEN;
        plain_start = 0;
        word_start  = 0;
        cs_begin    = 0;
        cs_count    = 0;
        star_seen   = 1'b0;
        enc_q       = 1'b0;
        pay_start   = 0;
        elem_count  = 0;
        halted      = 1'b0;
        forget_history();
    endtask

    task automatic queue_element(input logic [1:0] kind, input int unsigned doff, dlen,
                                 coff, clen, input bit fin);
        mews_pkg::elem_t e;
        e.kind = kind;
        e.doff = doff[9:0];
        e.dlen = dlen[10:0];
        e.coff = coff[9:0];
        e.clen = clen[4:0];
        e.fin  = fin;
        pending_elements.insert(pending_elements.size(), e);
    endtask

    // One header byte: advance the scanner and queue the elements it closes.
    task automatic scan_byte(input logic [7:0] b, input bit last);
        int unsigned i;
        int unsigned raw;
        int unsigned cnt;
        int unsigned span_end;
        logic [7:0]  u;
        bit          fin;
        if (!halted && pos < LINE_MAX_LEN)
        begin
            i = pos;
            case (ph)
                mews_pkg::PH_OPEN:
                begin
                    if (hist_n >= 1 && hist_new == mews_pkg::CH_EQ && b == mews_pkg::CH_QM)
                    begin
                        word_start = i - 1;
                        cs_begin   = i + 1;
                        cs_count   = 0;
                        star_seen  = 1'b0;
                        ph         = mews_pkg::PH_ENC;
                        forget_history();
                    end
                    else
                    begin
                        shift_history(b);
                    end
                end
                mews_pkg::PH_ENC:
                begin
                    u = fold_case(hist_new);
                    // first star inside the cap cuts the charset name
                    if (b == mews_pkg::CH_STAR && !star_seen &&
                        (i - cs_begin) < mews_pkg::CS_CAP)
                    begin
                        star_seen = 1'b1;
                        cs_count  = i - cs_begin;
                    end
                    if (hist_n >= 2 && hist_old == mews_pkg::CH_QM && b == mews_pkg::CH_QM &&
                        (u == mews_pkg::CH_B || u == mews_pkg::CH_Q))
                    begin
                        raw = i - 2 - cs_begin;
                        if (raw > mews_pkg::CS_CAP)
                        begin
                            raw = mews_pkg::CS_CAP;
                        end
                        if (!star_seen)
                        begin
                            cs_count = raw;
                        end
                        enc_q     = (u == mews_pkg::CH_Q);
                        pay_start = i + 1;
                        ph        = mews_pkg::PH_CLOSE;
                        forget_history();
                    end
                    else
                    begin
                        shift_history(b);
                    end
                end
                default:
                begin
                    if (hist_n >= 1 && hist_new == mews_pkg::CH_QM && b == mews_pkg::CH_EQ)
                    begin
                        cnt = elem_count + 2;
                        queue_element(mews_pkg::KIND_PLAIN, plain_start,
                                      word_start - plain_start, 0, 0, 1'b0);
                        fin = (cnt >= limit) || last || (i + 1 >= LINE_MAX_LEN);
                        queue_element(enc_q ? mews_pkg::KIND_Q : mews_pkg::KIND_B,
                                      pay_start, i - 1 - pay_start,
                                      cs_begin, cs_count, fin);
                        elem_count  = (cnt > 255) ? 255 : cnt;
                        plain_start = i + 1;
                        ph          = mews_pkg::PH_OPEN;
                        star_seen   = 1'b0;
                        cs_count    = 0;
                        forget_history();
                        if (fin)
                        begin
                            halted = 1'b1;
                        end
                    end
                    else
                    begin
                        shift_history(b);
                    end
                end
            endcase
            pos = i + 1;
        end
        if (last)
        begin
            // unfinished word or trailing text becomes one plain element
            if (!halted)
            begin
                span_end = (pos < LINE_MAX_LEN) ? pos : LINE_MAX_LEN;
                queue_element(mews_pkg::KIND_PLAIN, plain_start,
                              span_end - plain_start, 0, 0, 1'b1);
            end
            start_line();
        end
    endtask

    function automatic bit field_ok(input string name, input int unsigned exp_v, got_v);
        if (exp_v != got_v)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, got_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit = 8'd64;
            start_line();
            pending_elements.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_elements.size() == 0)
                begin
                    $display("%0t unexpected element: expected none, got kind %0d %h last %0b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = pending_elements.pop_front();
                    bad  = 1'b0;
                    bad |= !field_ok("element_kind", want.kind, m_axis_tuser);
                    bad |= !field_ok("data_offset", want.doff, m_axis_tdata[9:0]);
                    bad |= !field_ok("data_length", want.dlen, m_axis_tdata[20:10]);
                    bad |= !field_ok("charset_offset", want.coff, m_axis_tdata[30:21]);
                    bad |= !field_ok("charset_length", want.clen, m_axis_tdata[35:31]);
                    bad |= !field_ok("tdata padding", 0,
                                     m_axis_tdata[mews_pkg::TDATA_W-1:36]);
                    bad |= !field_ok("final_element", want.fin, m_axis_tlast);
                    if (bad)
                    begin
                        fail_count++;
                    end
                end
            end
            pending = pending_elements.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the encoded-word splitter: clock, reset, header line stimulus,
// output stalls and the verdict. Depends on mews_pkg and mews_element_checker.
module tb_top;
    localparam int LINE_LEN     = 1024;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;
    logic                           s_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mews_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           cfg_we;
    logic [7:0]                     cfg_wdata;

    int                   fail_count;
    int                   pending;
    int                   cyc = 0;
    bit                   hold_req = 1'b0;
    bit                   gaps_on = 1'b1;
    int                   burst_left = 0;
    logic [7:0]           line_buf[$];

    mime_encoded_word_splitter_top #(
        .LINE_MAX_LEN(LINE_LEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    mews_element_checker #(
        .LINE_MAX_LEN(LINE_LEN)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: stall modes that change every so often, plus a long hold-off
    // on request so the result queue fills and input backs up.
    initial
    begin
        int mode;
        int left;
        int k;
        m_axis_tready <= 1'b0;
        mode = 0;
        left = 0;
        k    = 0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                k++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (k % 3 != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one byte; bursts of random length with random gaps between them.
    task automatic send_word(input logic [7:0] b, input bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (gaps_on && $urandom_range(0, 9) > 2)
            begin
                gap = $urandom_range(1, 12);
            end
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_line();
        int n;
        n = line_buf.size();
        for (int k = 0; k < n; k++)
        begin
            send_word(line_buf[k], k == n - 1);
        end
        line_buf.delete();
    endtask

    task automatic put_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            put_byte(s[k]);
        end
    endtask

    task automatic add_letters(input int n);
        repeat (n) put_byte(8'($urandom_range(97, 122)));
    endtask

    task automatic add_text(input int n);
        repeat (n) put_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic add_noise(input int n);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
    endtask

    // Encoded word with random charset and payload; cut leaves only a prefix.
    task automatic add_word(input bit cut);
        string       cs_chars;
        string       enc_chars;
        string       pay_chars;
        logic [7:0]  w[$];
        int          cs_len;
        int          pay_len;
        int          star_at;
        int          keep;
        cs_chars  = "abcdefghijklmnopqrstuvwxyz0123456789-_UTF";
        enc_chars = "BbQqBbQqX";
        pay_chars = "abcXYZ09+/=_?= ";
        case ($urandom_range(0, 9))
            0:       cs_len = 0;
            1, 2:    cs_len = $urandom_range(28, 40);
            default: cs_len = $urandom_range(1, 12);
        endcase
        star_at = -1;
        if (cs_len > 0 && $urandom_range(0, 2) == 0)
        begin
            star_at = $urandom_range(0, cs_len - 1);
        end
        w.insert(w.size(), mews_pkg::CH_EQ);
        w.insert(w.size(), mews_pkg::CH_QM);
        for (int k = 0; k < cs_len; k++)
        begin
            if (k == star_at)
            begin
                w.insert(w.size(), mews_pkg::CH_STAR);
            end
            else
            begin
                w.insert(w.size(), cs_chars[$urandom_range(0, cs_chars.len() - 1)]);
            end
        end
        w.insert(w.size(), mews_pkg::CH_QM);
        w.insert(w.size(), enc_chars[$urandom_range(0, enc_chars.len() - 1)]);
        w.insert(w.size(), mews_pkg::CH_QM);
        pay_len = $urandom_range(0, 20);
        repeat (pay_len) w.insert(w.size(), pay_chars[$urandom_range(0, pay_chars.len() - 1)]);
        w.insert(w.size(), mews_pkg::CH_QM);
        w.insert(w.size(), mews_pkg::CH_EQ);
        keep = cut ? $urandom_range(1, w.size() - 1) : w.size();
        for (int k = 0; k < keep; k++)
        begin
            put_byte(w[k]);
        end
    endtask

    // Overlapping and stray markers.
    task automatic add_marker_mix();
        case ($urandom_range(0, 7))
            0: add_str("=?=?");
            1: add_str("?B?");
            2: add_str("?q?=");
            3: add_str("??==");
            4: add_str("=?*?");
            5: add_str("?=");
            6: add_str("=?a?b??=");
            default: add_str("=?=?B??=");
        endcase
    endtask

    task automatic build_line();
        int ntok;
        int r;
        ntok = $urandom_range(1, 5);
        repeat (ntok)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                add_word(1'b0);
            end
            else if (r < 65)
            begin
                add_text($urandom_range(0, 12));
            end
            else if (r < 75)
            begin
                add_word(1'b1);
            end
            else if (r < 85)
            begin
                add_noise($urandom_range(1, 6));
            end
            else
            begin
                add_marker_mix();
            end
        end
        if (line_buf.size() == 0)
        begin
            add_letters(1);
        end
    endtask

    task automatic run_random(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_line();
            sent += line_buf.size();
            send_line();
        end
    endtask

    // Input idle, every expected element out, then let the pipeline settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, limit at its reset value
        add_str("=?a*b?Q?x?=");         // empty text, star cut, word closes the line
        send_line();
        add_str("=?B?=");               // opener bytes not reused: stays unfinished
        send_line();
        put_byte(8'hFF);
        put_byte(8'h00);
        send_line();

        set_limit(8'd255);
        hold_req = 1'b1;
        run_random(200);
        // word whose close lands on the last usable position, then ignored bytes
        add_letters(LINE_LEN - 24);
        add_str("=?us-ascii?Q?");
        add_letters(9);
        add_str("?=");
        add_letters(20);
        send_line();

        set_limit(8'd1);
        run_random(100);

        set_limit(8'd0);
        run_random(80);

        set_limit(8'($urandom_range(2, 6)));
        gaps_on = 1'b0;
        run_random(120);
        gaps_on = 1'b1;

        set_limit(8'($urandom_range(1, 255)));
        hold_req = 1'b1;
        run_random(120);
        // overlong line with an unfinished word: remainder stops at the length cap
        add_letters(LINE_LEN - 14);
        add_str("=?abc?B?xyz");
        add_letters(20);
        send_line();

        set_limit(8'd64);
        run_random(120);

        wait_idle();
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
